// ===== hdl/mrfc_pkg.sv =====
// Shared constants, codes and the CRC polynomial and seed for the meter response frame checker.
package mrfc_pkg;

    localparam int MAX_FRAME_BYTES = 64;
    localparam int COUNT_W         = 7;
    localparam int STATUS_W        = 3;
    localparam int CRC_W           = 16;
    localparam int ADDR_W          = 32;
    localparam int BYTE_W          = 8;
    localparam int CFG_INDEX_W     = 1;
    localparam int CFG_DATA_W      = 32;
    localparam int S_TDATA_W       = 8;
    localparam int M_TDATA_W       = 16;

    localparam logic [CRC_W-1:0]   CRC_POLY      = 16'hA001;
    localparam logic [CRC_W-1:0]   CRC_INIT      = 16'hFFFF;
    localparam logic [COUNT_W-1:0] MIN_LEN_EXCL  = 7'd6;
    localparam logic [COUNT_W-1:0] COUNT_MAX     = COUNT_W'(MAX_FRAME_BYTES);
    localparam logic [COUNT_W-1:0] ADDR_BYTES    = 7'd4;

    localparam logic [CFG_INDEX_W-1:0] REG_DEVICE_ADDRESS   = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_EXPECTED_COMMAND = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_TOO_SHORT = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_CRC_ERR   = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_ADDR_ERR  = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_CMD_ERR   = 3'd4;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  frame_length;
    } result_t;

endpackage

// ===== hdl/meter_response_frame_check_top.sv =====
// Top level of the meter response frame checker.
// Takes one frame byte per cycle while s_tready is high and keeps the frame state in registers; the CRC step,
// the tail delay line and the checks sit between the frame registers and the result
// register, so the result of a frame appears in the cycle after its last byte is accepted.
// s_tready stays high while the result register is free or being drained; when a result
// waits, bytes that are not the last of a frame are still taken, and only a last byte
// stalls. Bytes past 64 kept bytes are ignored but a flagged one still ends the frame.
module meter_response_frame_check_top
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wen,
    input  logic [mrfc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [mrfc_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [mrfc_pkg::S_TDATA_W-1:0]      s_tdata,    // [7:0] rx_byte
    input  logic                                s_tlast,    // last_byte
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [mrfc_pkg::M_TDATA_W-1:0]      m_tdata     // [2:0] status, [9:3] frame_length
);

    logic [mrfc_pkg::ADDR_W-1:0]  dev_addr_reg;
    logic [mrfc_pkg::BYTE_W-1:0]  exp_cmd_reg;

    logic [mrfc_pkg::CRC_W-1:0]   crc_reg,   crc_next;
    logic [mrfc_pkg::CRC_W-1:0]   tail_reg,  tail_next;
    logic [mrfc_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [mrfc_pkg::ADDR_W-1:0]  addr_reg,  addr_next;
    logic [mrfc_pkg::BYTE_W-1:0]  cmd_reg,   cmd_next;

    logic                         out_valid_reg, out_valid_next;
    mrfc_pkg::result_t            result_reg,    result_next;

    logic                         accept;
    logic                         keep;
    logic [mrfc_pkg::CRC_W-1:0]   crc_fed;
    logic [mrfc_pkg::CRC_W-1:0]   crc_eff;
    logic [mrfc_pkg::CRC_W-1:0]   tail_eff;
    logic [mrfc_pkg::COUNT_W-1:0] count_eff;
    logic [mrfc_pkg::ADDR_W-1:0]  addr_eff;
    logic [mrfc_pkg::BYTE_W-1:0]  cmd_eff;
    logic [mrfc_pkg::CRC_W-1:0]   rx_crc;

    assign s_tready = !out_valid_reg || m_tready || !s_tlast;
    assign accept   = s_tvalid && s_tready;
    assign keep     = count_reg < mrfc_pkg::COUNT_MAX;

    mrfc_crc_step u_crc_step
    (
        .crc_in  (crc_reg),
        .data_in (tail_reg[mrfc_pkg::CRC_W-1:mrfc_pkg::BYTE_W]),
        .crc_out (crc_fed)
    );

    always_comb
    begin
        crc_eff   = crc_reg;
        tail_eff  = tail_reg;
        count_eff = count_reg;
        addr_eff  = addr_reg;
        cmd_eff   = cmd_reg;
        if (keep)
        begin
            if (count_reg >= 7'd2)
            begin
                crc_eff = crc_fed;
            end
            tail_eff  = {tail_reg[mrfc_pkg::BYTE_W-1:0], s_tdata};
            count_eff = count_reg + 7'd1;
            if (count_reg < mrfc_pkg::ADDR_BYTES)
            begin
                addr_eff = {addr_reg[mrfc_pkg::ADDR_W-mrfc_pkg::BYTE_W-1:0], s_tdata};
            end
            else if (count_reg == mrfc_pkg::ADDR_BYTES)
            begin
                cmd_eff = s_tdata;
            end
        end

        rx_crc = {tail_eff[mrfc_pkg::BYTE_W-1:0], tail_eff[mrfc_pkg::CRC_W-1:mrfc_pkg::BYTE_W]};

        result_next.frame_length = count_eff;
        priority if (count_eff <= mrfc_pkg::MIN_LEN_EXCL)
        begin
            result_next.status = mrfc_pkg::STATUS_TOO_SHORT;
        end
        else if (crc_eff != rx_crc)
        begin
            result_next.status = mrfc_pkg::STATUS_CRC_ERR;
        end
        else if (addr_eff != dev_addr_reg)
        begin
            result_next.status = mrfc_pkg::STATUS_ADDR_ERR;
        end
        else if (cmd_eff != exp_cmd_reg)
        begin
            result_next.status = mrfc_pkg::STATUS_CMD_ERR;
        end
        else
        begin
            result_next.status = mrfc_pkg::STATUS_OK;
        end

        crc_next   = crc_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        addr_next  = addr_reg;
        cmd_next   = cmd_reg;
        if (accept)
        begin
            if (s_tlast)
            begin
                crc_next   = mrfc_pkg::CRC_INIT;
                tail_next  = '0;
                count_next = '0;
                addr_next  = '0;
                cmd_next   = '0;
            end
            else
            begin
                crc_next   = crc_eff;
                tail_next  = tail_eff;
                count_next = count_eff;
                addr_next  = addr_eff;
                cmd_next   = cmd_eff;
            end
        end

        out_valid_next = out_valid_reg && !m_tready;
        if (accept && s_tlast)
        begin
            out_valid_next = 1'b1;
        end
    end

    // hold configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_addr_reg <= '0;
            exp_cmd_reg  <= '0;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                mrfc_pkg::REG_DEVICE_ADDRESS:
                begin
                    dev_addr_reg <= cfg_data;
                end
                mrfc_pkg::REG_EXPECTED_COMMAND:
                begin
                    exp_cmd_reg <= cfg_data[mrfc_pkg::BYTE_W-1:0];
                end
                default:
                begin
                    dev_addr_reg <= dev_addr_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg       <= mrfc_pkg::CRC_INIT;
            tail_reg      <= '0;
            count_reg     <= '0;
            addr_reg      <= '0;
            cmd_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            crc_reg       <= crc_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            addr_reg      <= addr_next;
            cmd_reg       <= cmd_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // load result on the last byte of a frame
    always_ff @(posedge clk)
    begin
        if (accept && s_tlast)
        begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(mrfc_pkg::M_TDATA_W-mrfc_pkg::STATUS_W-mrfc_pkg::COUNT_W){1'b0}},
                       result_reg.frame_length, result_reg.status};

endmodule

// ===== hdl/mrfc_crc_step.sv =====
// One byte of reflected CRC-16 (poly 0xA001), unrolled over eight bit steps.
module mrfc_crc_step
(
    input  logic [mrfc_pkg::CRC_W-1:0]  crc_in,
    input  logic [mrfc_pkg::BYTE_W-1:0] data_in,
    output logic [mrfc_pkg::CRC_W-1:0]  crc_out
);

    always_comb
    begin
        logic [mrfc_pkg::CRC_W-1:0] c;
        c = crc_in ^ {{(mrfc_pkg::CRC_W-mrfc_pkg::BYTE_W){1'b0}}, data_in};
        for (int k = 0; k < mrfc_pkg::BYTE_W; k++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ mrfc_pkg::CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        crc_out = c;
    end

endmodule
